/* design/sss_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sss_pkg: shared types and constants for the stack with sorted successor
// Command codes, status codes, the query word passed along the cell chain
// and the shift controls that move entries between neighboring cells.
// ----------------------------------------------------------------------------
package sss_pkg;

  localparam int DATA_W        = 32;
  localparam int DEPTH_DEFAULT = 16;
  localparam int S_TDATA_W     = 40;
  localparam int M_TDATA_W     = 40;

  typedef enum logic [2:0] {
    OP_PUSH     = 3'd0,
    OP_POP      = 3'd1,
    OP_PEEK     = 3'd2,
    OP_CLEAR    = 3'd3,
    OP_SEARCH   = 3'd4,
    OP_SMALLEST = 3'd5,
    OP_NEXT     = 3'd6,
    OP_NONE     = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  // Partial query answer handed from one cell to the next.
  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] value;
  } query_t;

  // Shift controls broadcast to every cell.
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage
`default_nettype wire

/* design/stack_with_sorted_successor.sv */
`timescale 1ns / 1ps
`default_nettype none
// Push, pop, peek, clear and the unused code finish in the accept cycle; the
// word is on the output in the cycle after acceptance.
// Search, smallest and next greater pass a query word down the chain of
// DEPTH cells, one cell per cycle; the result word is registered from the
// last cell once the pass is done. One command is worked on at a time.
// Reset empties the store (fill count zero) and drops any pending output word.
// ----------------------------------------------------------------------------
// stack_with_sorted_successor: bounded LIFO store with ordered queries
// A chain of cells holds the stack, top in cell 0. Queries run through the
// chain as a systolic pass; search sets hit, the others take the least match.
// ----------------------------------------------------------------------------
module stack_with_sorted_successor #(
  parameter int DEPTH = sss_pkg::DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // Fields from bit 0: opcode[2:0], operand[34:3], zero fill [39:35].
  input  wire logic [sss_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // Fields from bit 0: result_value[31:0], hit[32], status[34:33], zero fill.
  output logic [sss_pkg::M_TDATA_W-1:0]      m_axis_tdata
);
  import sss_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  state_t              state, state_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [CNT_W-1:0]    scan_cnt;
  opcode_t             q_op;
  logic [DATA_W-1:0]   q_arg;
  logic [DATA_W-1:0]   out_value;
  logic                out_hit;
  status_t             out_status;

  opcode_t             in_op;
  logic [DATA_W-1:0]   in_operand;
  logic                accept, is_query, out_free, scan_done, scan_load;
  shift_t              ctrl;
  logic [DATA_W-1:0]   res_value;
  logic                res_hit;
  status_t             res_status;

  logic [DATA_W-1:0]   cell_entry [DEPTH];
  query_t              cell_q     [DEPTH];

  assign in_op      = opcode_t'(s_axis_tdata[2:0]);
  assign in_operand = s_axis_tdata[DATA_W+2:3];
  assign accept     = s_axis_tvalid && s_axis_tready;
  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign scan_done  = (scan_cnt == CNT_W'(DEPTH));

  always_comb begin
    case (in_op) inside
      OP_SEARCH, OP_SMALLEST, OP_NEXT: is_query = 1'b1;
      default:                         is_query = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && is_query) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done && out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    s_axis_tready = (state == ST_IDLE) && out_free;
    scan_load     = (state == ST_SCAN) && scan_done && out_free;
  end

  // Commands that finish at once, and the shift they cause.
  always_comb begin
    ctrl       = '0;
    count_next = count;
    res_value  = '0;
    res_hit    = 1'b0;
    res_status = STAT_OK;
    case (in_op)
      OP_PUSH: begin
        if (count == CNT_W'(DEPTH)) begin
          res_status = STAT_FULL;
        end else begin
          ctrl.push  = accept;
          count_next = count + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (count == '0) begin
          res_status = STAT_EMPTY;
        end else begin
          ctrl.pop   = accept;
          count_next = count - CNT_W'(1);
        end
      end
      OP_PEEK: begin
        if (count == '0) begin
          res_status = STAT_EMPTY;
        end else begin
          res_value = cell_entry[0];
          res_hit   = 1'b1;
        end
      end
      OP_CLEAR: count_next = '0;
      default: count_next = count;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      scan_cnt      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        count <= count_next;
      end
      if (accept && is_query) begin
        scan_cnt <= '0;
      end else if (!scan_done) begin
        scan_cnt <= scan_cnt + CNT_W'(1);
      end
      if ((accept && !is_query) || scan_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Query operands and the output word.
  always_ff @(posedge clk) begin
    if (accept && is_query) begin
      q_op  <= in_op;
      q_arg <= in_operand;
    end
    if (accept && !is_query) begin
      out_value  <= res_value;
      out_hit    <= res_hit;
      out_status <= res_status;
    end else if (scan_load) begin
      out_value  <= cell_q[DEPTH-1].value;
      out_hit    <= cell_q[DEPTH-1].hit;
      out_status <= STAT_OK;
    end
  end

  assign m_axis_tdata = {(M_TDATA_W - DATA_W - 3)'(0), out_status, out_hit, out_value};

  // Chain of cells, top of the stack in cell 0.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] push_src, pop_src;
    query_t            q_src;
    logic              occ;

    if (i == 0) begin : g_first
      assign push_src = in_operand;
      assign q_src    = '0;
    end else begin : g_rest
      assign push_src = cell_entry[i-1];
      assign q_src    = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign pop_src = cell_entry[i];
    end else begin : g_inner
      assign pop_src = cell_entry[i+1];
    end

    assign occ = (CNT_W'(i) < count);

    sss_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .push_in  (push_src),
      .pop_in   (pop_src),
      .occupied (occ),
      .q_op     (q_op),
      .q_arg    (q_arg),
      .q_in     (q_src),
      .q_out    (cell_q[i]),
      .entry    (cell_entry[i])
    );
  end

endmodule
`default_nettype wire

/* design/sss_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sss_cell: one storage cell of the stack chain
// Holds one entry, shifts it toward the bottom on push and toward the top
// on pop, and folds its entry into the query word passing through it.
// ----------------------------------------------------------------------------
module sss_cell (
  input  wire logic                       clk,
  input  wire sss_pkg::shift_t            ctrl,
  input  wire logic [sss_pkg::DATA_W-1:0] push_in,
  input  wire logic [sss_pkg::DATA_W-1:0] pop_in,
  input  wire logic                       occupied,
  input  wire sss_pkg::opcode_t           q_op,
  input  wire logic [sss_pkg::DATA_W-1:0] q_arg,
  input  wire sss_pkg::query_t            q_in,
  output sss_pkg::query_t                 q_out,
  output logic [sss_pkg::DATA_W-1:0]      entry
);
  import sss_pkg::*;

  query_t q_next;
  logic   take;

  // Entry register: a push takes the value above, a pop the value below.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      entry <= push_in;
    end else if (ctrl.pop) begin
      entry <= pop_in;
    end
  end

  // Fold this cell's entry into the running answer.
  always_comb begin
    q_next = q_in;
    take   = 1'b0;
    case (q_op)
      OP_SEARCH: begin
        if (occupied && (entry == q_arg)) begin
          q_next.hit = 1'b1;
        end
      end
      OP_SMALLEST: begin
        take = occupied && (!q_in.hit || ($signed(entry) < $signed(q_in.value)));
      end
      OP_NEXT: begin
        take = occupied && ($signed(entry) > $signed(q_arg)) &&
               (!q_in.hit || ($signed(entry) < $signed(q_in.value)));
      end
      default: begin
        q_next = q_in;
      end
    endcase
    if (take) begin
      q_next.hit   = 1'b1;
      q_next.value = entry;
    end
  end

  // Stage register toward the next cell.
  always_ff @(posedge clk) begin
    q_out <= q_next;
  end

endmodule
`default_nettype wire
